// ----- src/pdsp_pkg.sv -----
// Shared types and constants for the pulse duration symbol packer.
`timescale 1ns / 1ps
`default_nettype none

package pdsp_pkg;

	localparam int DUR_W         = 22;
	localparam int LEN_W         = 15;
	localparam int MAX_CHUNKS    = 127;
	localparam int CHUNK_MAX_DEF = 32767;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_PAD
	} state_t;

	typedef struct packed {
		logic load;
		logic advance;
	} chunk_ctl_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             last;
	} chunk_t;

	typedef struct packed {
		logic [LEN_W-1:0] first_length;
		logic             first_level;
		logic [LEN_W-1:0] second_length;
		logic             second_level;
		logic             last;
	} word_t;

	typedef struct packed {
		state_t state;
		logic   held_valid;
	} seq_status_t;

endpackage

`default_nettype wire

// ----- src/pulse_duration_symbol_packer.sv -----
// Top level of the pulse duration symbol packer.
// Usage:
//   The item channel (item_valid, item_stall, duration, frame_end) takes one
//   mark/space duration of an IR frame per transaction. Levels alternate from
//   mark at each frame start. Each duration, saturated at 127 chunks, is cut
//   into chunks of at most CHUNK_MAX ticks; chunks pair into symbol words on
//   the word channel (word_valid, word_stall and the five word fields).
//   The last word of a frame has word_last set, padded with a zero half if odd.
//   An item is loaded, then cut chunk by chunk through the shared
//   compare-and-subtract unit, plus a padded word where one is needed, with
//   item_stall high until the item is done. A word appears in the cycle after
//   it is formed; the output register lets the next chunk be cut while a word
//   waits. While word_stall is high the word holds, and the sequencer
//   halts on the next word it would form.
//   Reset clears the held half, sets the level to mark and empties the
//   output register; no item is lost across frames.
`timescale 1ns / 1ps
`default_nettype none

module pulse_duration_symbol_packer
	import pdsp_pkg::*;
#(
	parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire logic [DUR_W-1:0] duration,
	input  wire logic             frame_end,
	output logic                  word_valid,
	input  wire logic             word_stall,
	output logic [LEN_W-1:0]      first_length,
	output logic                  first_level,
	output logic [LEN_W-1:0]      second_length,
	output logic                  second_level,
	output logic                  word_last
);

	chunk_ctl_t  ctl;
	chunk_t      chunk;
	word_t       word;
	word_t       word_out;
	seq_status_t status;
	logic        idle;
	logic        push;
	logic        out_ready;
	logic        item_accept;

	assign item_stall  = !idle;
	assign item_accept = item_valid && idle;

	pdsp_chunk_unit #(
		.CHUNK_MAX(CHUNK_MAX)
	) u_chunk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.duration (duration),
		.chunk    (chunk)
	);

	pdsp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (item_accept),
		.frame_end   (frame_end),
		.chunk       (chunk),
		.out_ready   (out_ready),
		.ctl         (ctl),
		.idle        (idle),
		.push        (push),
		.word        (word),
		.status      (status)
	);

	pdsp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.word_in  (word),
		.stall    (word_stall),
		.ready    (out_ready),
		.valid    (word_valid),
		.word_out (word_out)
	);

	assign first_length  = word_out.first_length;
	assign first_level   = word_out.first_level;
	assign second_length = word_out.second_length;
	assign second_level  = word_out.second_level;
	assign word_last     = word_out.last;

	a_pad_has_half: assert property (@(posedge clk) disable iff (!arst_n)
		(status.state == ST_PAD) |-> status.held_valid)
		else $error("pad state without a held half");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(push && word.last) |=> (status.state == ST_IDLE && !status.held_valid))
		else $error("last word did not end the item");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (status.state == ST_SPLIT))
		else $error("accepted transaction did not start splitting");

endmodule

`default_nettype wire

// ----- src/pdsp_chunk_unit.sv -----
// Remaining-duration register with the shared compare and subtract that cuts chunks.
`timescale 1ns / 1ps
`default_nettype none

module pdsp_chunk_unit
	import pdsp_pkg::*;
#(
	parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire chunk_ctl_t       ctl,
	input  wire logic [DUR_W-1:0] duration,
	output chunk_t                chunk
);

	localparam int unsigned CAP = MAX_CHUNKS * CHUNK_MAX;

	logic [DUR_W-1:0] rem_q;
	logic             over_max;
	logic [DUR_W-1:0] sat_duration;

	assign over_max     = rem_q > DUR_W'(CHUNK_MAX);
	assign sat_duration = (duration > DUR_W'(CAP)) ? DUR_W'(CAP) : duration;

	always_comb begin
		chunk.length = over_max ? LEN_W'(CHUNK_MAX) : rem_q[LEN_W-1:0];
		chunk.last   = !over_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= sat_duration;
		end else if (ctl.advance) begin
			rem_q <= rem_q - DUR_W'(chunk.length);
		end
	end

endmodule

`default_nettype wire

// ----- src/pdsp_seq.sv -----
// Sequencer that pairs chunks into symbol words and tracks the held half and level.
`timescale 1ns / 1ps
`default_nettype none

module pdsp_seq
	import pdsp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   item_accept,
	input  wire logic   frame_end,
	input  wire chunk_t chunk,
	input  wire logic   out_ready,
	output chunk_ctl_t  ctl,
	output logic        idle,
	output logic        push,
	output word_t       word,
	output seq_status_t status
);

	state_t           st_q, st_d;
	logic             held_valid_q, held_valid_d;
	logic [LEN_W-1:0] held_length_q, held_length_d;
	logic             held_level_q, held_level_d;
	logic             level_q, level_d;
	logic             fend_q, fend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			held_valid_q <= 1'b0;
			level_q      <= 1'b1;
			fend_q       <= 1'b0;
		end else begin
			st_q         <= st_d;
			held_valid_q <= held_valid_d;
			level_q      <= level_d;
			fend_q       <= fend_d;
		end
	end

	always_ff @(posedge clk) begin
		held_length_q <= held_length_d;
		held_level_q  <= held_level_d;
	end

	always_comb begin
		st_d          = st_q;
		held_valid_d  = held_valid_q;
		held_length_d = held_length_q;
		held_level_d  = held_level_q;
		level_d       = level_q;
		fend_d        = fend_q;
		ctl.load      = 1'b0;
		ctl.advance   = 1'b0;
		push          = 1'b0;
		idle          = 1'b0;
		word.first_length  = held_length_q;
		word.first_level   = held_level_q;
		word.second_length = chunk.length;
		word.second_level  = level_q;
		word.last          = fend_q && chunk.last;
		case (st_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (item_accept) begin
					ctl.load = 1'b1;
					fend_d   = frame_end;
					st_d     = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				if (!held_valid_q || out_ready) begin
					ctl.advance = 1'b1;
					if (held_valid_q) begin
						push         = 1'b1;
						held_valid_d = 1'b0;
					end else begin
						held_valid_d  = 1'b1;
						held_length_d = chunk.length;
						held_level_d  = level_q;
					end
					if (chunk.last) begin
						if (!fend_q) begin
							level_d = !level_q;
							st_d    = ST_IDLE;
						end else if (held_valid_q) begin
							level_d = 1'b1;
							st_d    = ST_IDLE;
						end else begin
							st_d = ST_PAD;
						end
					end
				end
			end
			ST_PAD: begin
				word.second_length = '0;
				word.second_level  = 1'b0;
				word.last          = 1'b1;
				if (out_ready) begin
					push         = 1'b1;
					held_valid_d = 1'b0;
					level_d      = 1'b1;
					st_d         = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		status.state      = st_q;
		status.held_valid = held_valid_q;
	end

endmodule

`default_nettype wire

// ----- src/pdsp_out_reg.sv -----
// Output register holding one symbol word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module pdsp_out_reg
	import pdsp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire word_t word_in,
	input  wire logic  stall,
	output logic       ready,
	output logic       valid,
	output word_t      word_out
);

	logic  valid_q;
	word_t word_q;

	assign ready    = !valid_q || !stall;
	assign valid    = valid_q;
	assign word_out = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && push) begin
			word_q <= word_in;
		end
	end

endmodule

`default_nettype wire

// ----- tb/pdsp_word_checker.sv -----
// Checker for the pulse duration symbol packer: predicts symbol words and compares them.
`timescale 1ns / 1ps

module pdsp_word_checker
	import pdsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  logic [DUR_W-1:0] duration,
	input  logic             frame_end,
	input  logic             word_valid,
	input  logic             word_stall,
	input  logic [LEN_W-1:0] first_length,
	input  logic             first_level,
	input  logic [LEN_W-1:0] second_length,
	input  logic             second_level,
	input  logic             word_last,
	output int               errors,
	output int               pending
);

	localparam int unsigned DUR_CAP = MAX_CHUNKS * CHUNK_MAX_DEF;

	word_t            expected_words[$];
	word_t            seen;
	logic             half_held = 1'b0;
	logic [LEN_W-1:0] held_len  = '0;
	logic             held_lvl  = 1'b0;
	logic             mark_next = 1'b1;
	int               fail_count = 0;
	int               queued     = 0;

	assign errors  = fail_count;
	assign pending = queued;

	task automatic pack_duration(input logic [DUR_W-1:0] dur, input logic fend);
		int unsigned      left;
		logic [LEN_W-1:0] piece;
		logic             lvl;
		word_t            w;
		int               count;
		left  = (dur > DUR_CAP) ? DUR_CAP : int'(dur);
		lvl   = mark_next;
		count = 0;
		do begin
			piece = (left > CHUNK_MAX_DEF) ? LEN_W'(CHUNK_MAX_DEF) : LEN_W'(left);
			if (half_held) begin
				w = '{held_len, held_lvl, piece, lvl, 1'b0};
				expected_words.push_back(w);
				count++;
				half_held = 1'b0;
				held_len  = '0;
				held_lvl  = 1'b0;
			end else begin
				half_held = 1'b1;
				held_len  = piece;
				held_lvl  = lvl;
			end
			left -= piece;
		end while (left != 0);
		if (fend) begin
			// pad the odd half with a zero-length space
			if (half_held) begin
				w = '{held_len, held_lvl, LEN_W'(0), 1'b0, 1'b0};
				expected_words.push_back(w);
				count++;
			end
			if (count > 0) begin
				w      = expected_words.pop_back();
				w.last = 1'b1;
				expected_words.push_back(w);
			end
			half_held = 1'b0;
			held_len  = '0;
			held_lvl  = 1'b0;
			mark_next = 1'b1;
		end else begin
			mark_next = ~lvl;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			half_held = 1'b0;
			held_len  = '0;
			held_lvl  = 1'b0;
			mark_next = 1'b1;
			queued   <= 0;
		end else begin
			if (word_valid && !word_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected symbol word: first_length %0d, second_length %0d",
						first_length, second_length);
					fail_count++;
				end else begin
					seen = expected_words.pop_front();
					check_field("first_length", seen.first_length, first_length);
					check_field("first_level", seen.first_level, first_level);
					check_field("second_length", seen.second_length, second_length);
					check_field("second_level", seen.second_level, second_level);
					check_field("word_last", seen.last, word_last);
				end
			end
			if (item_valid && !item_stall)
				pack_duration(duration, frame_end);
			queued <= expected_words.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the pulse duration symbol packer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
	import pdsp_pkg::*;
();

	localparam int          QUIET_LIMIT = 4000;
	localparam int          HOLD_CYCLES = 300;
	localparam int          DRAIN_CYCLES = 140;
	localparam int unsigned DUR_CAP = MAX_CHUNKS * CHUNK_MAX_DEF;
	localparam int          N_DIRECTED = 21;
	localparam int unsigned DIRECTED_DUR [N_DIRECTED] = '{
		0, 1, 32767, 32768, 0, 0, 0, 65534, 65535, 4161409, 4161410,
		4194303, 1, 12345, 600, 9000, 2, 3, 2097152, 1398101, 2796202
	};
	localparam bit DIRECTED_END [N_DIRECTED] = '{
		1, 0, 0, 1, 0, 0, 1, 0, 1, 1, 1,
		0, 1, 0, 0, 1, 1, 1, 0, 0, 1
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	logic [DUR_W-1:0] duration;
	logic             frame_end;
	logic             word_valid;
	logic             word_stall;
	logic [LEN_W-1:0] first_length;
	logic             first_level;
	logic [LEN_W-1:0] second_length;
	logic             second_level;
	logic             word_last;
	int               errors;
	int               pending;
	logic             rx_calm = 1'b0;
	logic             hold_go = 1'b0;
	bit               tx_calm;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pulse_duration_symbol_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.duration     (duration),
		.frame_end    (frame_end),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.first_length (first_length),
		.first_level  (first_level),
		.second_length(second_length),
		.second_level (second_level),
		.word_last    (word_last)
	);

	pdsp_word_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.duration     (duration),
		.frame_end    (frame_end),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.first_length (first_length),
		.first_level  (first_level),
		.second_length(second_length),
		.second_level (second_level),
		.word_last    (word_last),
		.errors       (errors),
		.pending      (pending)
	);

	function automatic logic [DUR_W-1:0] pick_duration();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return DUR_W'($urandom_range(3000));
		else if (r < 80)
			return DUR_W'($urandom_range(100000, 3001));
		else if (r < 92)
			return DUR_W'($urandom_range(600000, 100001));
		else if (r < 96)
			return DUR_W'($urandom);
		else if (r < 98)
			return DUR_W'($urandom_range((1 << DUR_W) - 1, DUR_CAP - 1));
		return '0;
	endfunction

	task automatic send_duration(input logic [DUR_W-1:0] dur, input logic fend);
		while (!tx_calm && $urandom_range(99) < 38) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		duration   <= dur;
		frame_end  <= fend;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_random(input int count, input bit close_frame);
		for (int i = 0; i < count; i++)
			send_duration(pick_duration(),
				(close_frame && i == count - 1) || $urandom_range(99) < 15);
	endtask

	// receiver: random stalls, calm stretches and one long hold-off
	initial begin : receiver
		int  hold_left;
		bit  hold_started;
		hold_left    = 0;
		hold_started = 0;
		word_stall   = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_started) begin
				hold_started = 1;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				word_stall <= 1'b1;
				hold_left--;
			end else if (rx_calm) begin
				word_stall <= 1'b0;
			end else begin
				word_stall <= ($urandom_range(99) < 38);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (word_valid && !word_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		arst_n     = 1'b0;
		item_valid = 1'b0;
		duration   = '0;
		frame_end  = 1'b0;
		tx_calm    = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_duration(DUR_W'(DIRECTED_DUR[i]), DIRECTED_END[i]);

		send_random(50, 0);

		// calm stretch: no idling on either side
		tx_calm = 1;
		rx_calm <= 1'b1;
		send_random(35, 0);

		// hold the receiver off while items keep coming
		rx_calm <= 1'b0;
		hold_go <= 1'b1;
		send_random(30, 0);

		tx_calm = 0;
		send_random(45, 1);
		item_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
